>>> rtl/core/mcam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcam_pkg
// Shared types and constants for the minimum-cost assignment matcher.
// ----------------------------------------------------------------------------
package mcam_pkg;

    localparam int VAL_W = 24;
    localparam logic [VAL_W-1:0] SAT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] cost;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [4:0]  row_count;
        logic [4:0]  col_count;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [3:0] out_row;
        logic [3:0] assigned_col;
        logic       assigned;
        logic       last_result;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RED_MIN,
        ST_RED_SUB,
        ST_COUNT,
        ST_PRIME,
        ST_ADJ_MIN,
        ST_ADJ_UPD,
        ST_AUG_INIT,
        ST_AUG_STEP,
        ST_AUG_END,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        CMD_LOAD,
        CMD_NOP,
        CMD_RED_MIN,
        CMD_RED_SUB,
        CMD_PRIME,
        CMD_ADJ_MIN,
        CMD_ADJ_UPD,
        CMD_AUG_INIT,
        CMD_AUG_STEP,
        CMD_AUG_END,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic rows_zero;
        logic cols_zero;
        logic line_end;
        logic sweep_end;
        logic count_done;
        logic prime_hit;
        logic again;
        logic h_found;
        logic aug_stop;
        logic emit_fire;
        logic emit_last;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/mcam_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcam_dp
// Datapath: cost memory, sweep counters, star/prime/cover marks, result reg.
// ----------------------------------------------------------------------------
module mcam_dp #(
    parameter int MAX_SIZE  = 16,
    parameter int COST_BITS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  mcam_pkg::cmd_t        cmd,
    input  wire                   item_valid,
    input  mcam_pkg::item_t       item,
    output mcam_pkg::result_t     result,
    output logic                  result_valid,
    input  wire                   result_ready,
    output mcam_pkg::dp_status_t  status
);

    localparam int IW    = $clog2(MAX_SIZE);
    localparam int CW    = $clog2(MAX_SIZE + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int VW    = mcam_pkg::VAL_W;
    localparam logic [15:0] CMASK =
        (COST_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COST_BITS) - 32'd1);

    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] rd_reg;

    logic [CW-1:0] nr_reg, nc_reg;
    logic          tr_reg, ok_reg;
    logic [IW-1:0] o_reg, i_reg, o_next, i_next;
    logic          ph_reg, ph_next;
    logic [VW-1:0] m_reg, h_reg;
    logic          hf_reg, again_reg, done_line_reg;
    logic [IW-1:0] pr_reg, pc_reg, cs_reg, er_reg;
    logic [MAX_SIZE-1:0] star_reg  [MAX_SIZE];
    logic [MAX_SIZE-1:0] scr_reg   [MAX_SIZE];
    logic [MAX_SIZE-1:0] prime_reg [MAX_SIZE];
    logic [MAX_SIZE-1:0] covc_reg, covr_reg;
    logic          out_valid_reg;
    mcam_pkg::result_t out_reg;

    logic          accept, in_range;
    logic          red, colmaj;
    logic [IW-1:0] row, col, srow, scol, rs, c2;
    logic [AW-1:0] addr;
    logic [CW-1:0] ol, il, cnt, dmin, nr_in, nc_in;
    logic          i_last, o_last;
    logic          go_elem, go_line, hold_outer, clr_cnt, outer_step;
    logic          line_end, sweep_end;
    logic          sfound, rsf, c2f;
    logic          p1;
    logic          star_now, set_again, h_take;
    logic [MAX_SIZE-1:0] rmask, cov_add;
    logic [VW-1:0] v, sub_m, add_h, adj_w;
    logic [VW:0]   sum_h;
    logic          we;
    logic [AW-1:0] wa;
    logic [VW-1:0] wd;
    logic          emit_fire;

    assign v      = rd_reg;
    assign accept = (cmd == mcam_pkg::CMD_LOAD) && item_valid;
    assign in_range = ({1'b0, item.row_index} < 5'(MAX_SIZE))
                   && ({1'b0, item.col_index} < 5'(MAX_SIZE));
    assign nr_in = (item.row_count > 5'(MAX_SIZE)) ? CW'(MAX_SIZE) : CW'(item.row_count);
    assign nc_in = (item.col_count > 5'(MAX_SIZE)) ? CW'(MAX_SIZE) : CW'(item.col_count);

    assign red    = (cmd == mcam_pkg::CMD_RED_MIN) || (cmd == mcam_pkg::CMD_RED_SUB);
    assign colmaj = red ? tr_reg : 1'b1;
    assign row    = colmaj ? i_reg : o_reg;
    assign col    = colmaj ? o_reg : i_reg;
    assign addr   = {row, col};
    assign ol     = (red && !tr_reg) ? nr_reg : nc_reg;
    assign il     = (red && !tr_reg) ? nc_reg : nr_reg;
    assign i_last = (CW'(i_reg) + CW'(1)) == il;
    assign o_last = (CW'(o_reg) + CW'(1)) == ol;
    assign p1     = ph_reg;
    assign dmin   = tr_reg ? nc_reg : nr_reg;
    assign srow   = (cmd == mcam_pkg::CMD_EMIT) ? er_reg : row;

    // searches over mark rows and columns, lowest index wins
    always_comb
    begin
        sfound = 1'b0; scol = '0;
        rsf = 1'b0; rs = '0;
        c2f = 1'b0; c2 = '0;
        cnt = '0;
        for (int k = MAX_SIZE - 1; k >= 0; k--)
        begin
            rmask[k] = CW'(k) < nr_reg;
            if (star_reg[k][srow] && (CW'(k) < nc_reg))
            begin
                sfound = 1'b1;
                scol   = IW'(k);
            end
            if (star_reg[cs_reg][k] && (CW'(k) < nr_reg))
            begin
                rsf = 1'b1;
                rs  = IW'(k);
            end
        end
        for (int k = MAX_SIZE - 1; k >= 0; k--)
        begin
            if (prime_reg[k][rs] && (CW'(k) < nc_reg))
            begin
                c2f = 1'b1;
                c2  = IW'(k);
            end
            cov_add[k] = (|(scr_reg[k] & rmask)) && (CW'(k) < nc_reg);
            cnt = cnt + CW'(covc_reg[k]);
        end
    end

    // sweep sequencing
    always_comb
    begin
        o_next = o_reg; i_next = i_reg; ph_next = ph_reg;
        go_elem = 1'b0; go_line = 1'b0; hold_outer = 1'b0; clr_cnt = 1'b0;
        outer_step = 1'b0; line_end = 1'b0; sweep_end = 1'b0;
        case (cmd)
            mcam_pkg::CMD_RED_MIN:
            begin
                if (!p1) ph_next = 1'b1;
                else
                begin
                    go_elem = 1'b1;
                    hold_outer = 1'b1;
                end
            end
            mcam_pkg::CMD_RED_SUB:
            begin
                if (!p1) ph_next = 1'b1;
                else go_elem = 1'b1;
            end
            mcam_pkg::CMD_PRIME:
            begin
                if (!p1)
                begin
                    if (covc_reg[col]) go_line = 1'b1;
                    else if (covr_reg[row]) go_elem = 1'b1;
                    else ph_next = 1'b1;
                end
                else if (v == '0)
                begin
                    if (!sfound) clr_cnt = 1'b1;
                    else go_line = 1'b1;
                end
                else go_elem = 1'b1;
            end
            mcam_pkg::CMD_ADJ_MIN:
            begin
                if (!p1 && !covr_reg[row] && !covc_reg[col]) ph_next = 1'b1;
                else go_elem = 1'b1;
            end
            mcam_pkg::CMD_ADJ_UPD:
            begin
                if (!p1 && (covr_reg[row] || !covc_reg[col])) ph_next = 1'b1;
                else go_elem = 1'b1;
            end
            default: ;
        endcase
        if (go_elem)
        begin
            ph_next = 1'b0;
            if (i_last)
            begin
                i_next = '0;
                line_end = 1'b1;
                outer_step = !hold_outer;
            end
            else i_next = i_reg + IW'(1);
        end
        if (go_line)
        begin
            ph_next = 1'b0;
            i_next = '0;
            line_end = 1'b1;
            outer_step = 1'b1;
        end
        if (outer_step)
        begin
            if (o_last)
            begin
                o_next = '0;
                sweep_end = 1'b1;
            end
            else o_next = o_reg + IW'(1);
        end
        if (clr_cnt)
        begin
            o_next = '0; i_next = '0; ph_next = 1'b0;
        end
    end

    // element arithmetic and memory write port
    always_comb
    begin
        sub_m = v - m_reg;
        sum_h = {1'b0, v} + {1'b0, h_reg};
        add_h = sum_h[VW] ? mcam_pkg::SAT_MAX
              : ((sum_h[VW-1:0] > mcam_pkg::SAT_MAX) ? mcam_pkg::SAT_MAX : sum_h[VW-1:0]);
        adj_w = covr_reg[row] ? add_h : v;
        if (!covc_reg[col]) adj_w = adj_w - h_reg;
        star_now = (cmd == mcam_pkg::CMD_RED_SUB) && p1 && (sub_m == '0) && !done_line_reg
                && !(tr_reg ? covr_reg[row] : covc_reg[col]);
        set_again = (cmd == mcam_pkg::CMD_PRIME) && p1 && (v == '0) && sfound;
        h_take = (cmd == mcam_pkg::CMD_ADJ_MIN) && p1 && (!hf_reg || (v < h_reg));
        we = 1'b0; wa = addr; wd = sub_m;
        if (accept)
        begin
            we = in_range;
            wa = {item.row_index[IW-1:0], item.col_index[IW-1:0]};
            wd = VW'(item.cost & CMASK);
        end
        else if ((cmd == mcam_pkg::CMD_RED_SUB) && p1) we = 1'b1;
        else if ((cmd == mcam_pkg::CMD_ADJ_UPD) && p1)
        begin
            we = 1'b1;
            wd = adj_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[wa] <= wd;
        rd_reg <= mem[addr];
    end

    assign emit_fire = (cmd == mcam_pkg::CMD_EMIT) && (!out_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nr_reg <= '0; nc_reg <= '0; tr_reg <= 1'b0; ok_reg <= 1'b0;
            o_reg <= '0; i_reg <= '0; ph_reg <= 1'b0;
            hf_reg <= 1'b0; again_reg <= 1'b0; done_line_reg <= 1'b0;
            pr_reg <= '0; pc_reg <= '0; cs_reg <= '0; er_reg <= '0;
            covc_reg <= '0; covr_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_SIZE; k++)
            begin
                star_reg[k] <= '0; scr_reg[k] <= '0; prime_reg[k] <= '0;
            end
        end
        else
        begin
            o_reg <= o_next; i_reg <= i_next; ph_reg <= ph_next;
            if (accept && item.last)
            begin
                nr_reg <= nr_in; nc_reg <= nc_in; tr_reg <= nr_in > nc_in;
                ok_reg <= 1'b1; er_reg <= '0;
                o_reg <= '0; i_reg <= '0; ph_reg <= 1'b0;
                hf_reg <= 1'b0; again_reg <= 1'b0; done_line_reg <= 1'b0;
                covc_reg <= '0; covr_reg <= '0;
                for (int k = 0; k < MAX_SIZE; k++)
                begin
                    star_reg[k] <= '0; scr_reg[k] <= '0; prime_reg[k] <= '0;
                end
            end
            // row or column reduction, starring the first free zero of each line
            if (star_now)
            begin
                star_reg[col][row] <= 1'b1;
                covc_reg[col] <= 1'b1;
                if (tr_reg) covr_reg[row] <= 1'b1;
            end
            if ((cmd == mcam_pkg::CMD_RED_SUB) && line_end) done_line_reg <= 1'b0;
            else if (star_now) done_line_reg <= 1'b1;
            if ((cmd == mcam_pkg::CMD_RED_SUB) && sweep_end && tr_reg) covr_reg <= '0;
            // prime uncovered zeros
            if ((cmd == mcam_pkg::CMD_PRIME) && p1 && (v == '0))
            begin
                prime_reg[col][row] <= 1'b1;
                if (!sfound)
                begin
                    pr_reg <= row;
                    pc_reg <= col;
                end
            end
            if (set_again)
            begin
                covr_reg[row] <= 1'b1;
                covc_reg[scol] <= 1'b0;
            end
            if ((cmd == mcam_pkg::CMD_PRIME) && sweep_end) again_reg <= 1'b0;
            else if (set_again) again_reg <= 1'b1;
            // line minimum for reduction, least uncovered value for adjustment
            if ((cmd == mcam_pkg::CMD_RED_MIN) && p1)
            begin
                if (i_reg == '0 || v < m_reg) m_reg <= v;
            end
            if (h_take)
            begin
                h_reg <= v;
                hf_reg <= 1'b1;
            end
            if ((cmd == mcam_pkg::CMD_ADJ_MIN) && sweep_end)
            begin
                hf_reg <= 1'b0;
                if (!(hf_reg || h_take)) ok_reg <= 1'b0;
            end
            // alternating path
            if (cmd == mcam_pkg::CMD_AUG_INIT)
            begin
                for (int k = 0; k < MAX_SIZE; k++) scr_reg[k] <= star_reg[k];
                scr_reg[pc_reg][pr_reg] <= 1'b1;
                cs_reg <= pc_reg;
            end
            if ((cmd == mcam_pkg::CMD_AUG_STEP) && rsf)
            begin
                scr_reg[cs_reg][rs] <= 1'b0;
                if (c2f)
                begin
                    scr_reg[c2][rs] <= 1'b1;
                    cs_reg <= c2;
                end
            end
            if (cmd == mcam_pkg::CMD_AUG_END)
            begin
                for (int k = 0; k < MAX_SIZE; k++)
                begin
                    star_reg[k] <= scr_reg[k];
                    prime_reg[k] <= '0;
                end
                covr_reg <= '0;
                covc_reg <= covc_reg | cov_add;
            end
            // result register
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                er_reg <= er_reg + IW'(1);
            end
            else if (result_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg.out_row      <= 4'(er_reg);
            out_reg.assigned_col <= (ok_reg && sfound) ? 4'(scol) : 4'd0;
            out_reg.assigned     <= ok_reg && sfound;
            out_reg.last_result  <= (CW'(er_reg) + CW'(1)) == nr_reg;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        status.load_last  = accept && item.last;
        status.rows_zero  = nr_reg == '0;
        status.cols_zero  = nc_reg == '0;
        status.line_end   = line_end;
        status.sweep_end  = sweep_end;
        status.count_done = cnt == dmin;
        status.prime_hit  = clr_cnt;
        status.again      = again_reg || set_again;
        status.h_found    = hf_reg || h_take;
        status.aug_stop   = !rsf || !c2f;
        status.emit_fire  = emit_fire;
        status.emit_last  = (CW'(er_reg) + CW'(1)) == nr_reg;
    end

endmodule
`default_nettype wire

>>> rtl/core/mcam_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcam_ctrl
// Solve sequencer: steps the datapath through reduce, prime, adjust, augment.
// ----------------------------------------------------------------------------
module mcam_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mcam_pkg::dp_status_t status,
    output mcam_pkg::cmd_t       cmd,
    output logic                 item_ready
);

    mcam_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= mcam_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = mcam_pkg::CMD_NOP;
        item_ready = 1'b0;
        case (state_reg)
            mcam_pkg::ST_IDLE:
            begin
                cmd = mcam_pkg::CMD_LOAD;
                item_ready = 1'b1;
                if (status.load_last) state_next = mcam_pkg::ST_START;
            end
            mcam_pkg::ST_START:
            begin
                if (status.rows_zero) state_next = mcam_pkg::ST_IDLE;
                else if (status.cols_zero) state_next = mcam_pkg::ST_COUNT;
                else state_next = mcam_pkg::ST_RED_MIN;
            end
            mcam_pkg::ST_RED_MIN:
            begin
                cmd = mcam_pkg::CMD_RED_MIN;
                if (status.line_end) state_next = mcam_pkg::ST_RED_SUB;
            end
            mcam_pkg::ST_RED_SUB:
            begin
                cmd = mcam_pkg::CMD_RED_SUB;
                if (status.sweep_end) state_next = mcam_pkg::ST_COUNT;
                else if (status.line_end) state_next = mcam_pkg::ST_RED_MIN;
            end
            mcam_pkg::ST_COUNT:
            begin
                if (status.count_done) state_next = mcam_pkg::ST_EMIT;
                else state_next = mcam_pkg::ST_PRIME;
            end
            mcam_pkg::ST_PRIME:
            begin
                cmd = mcam_pkg::CMD_PRIME;
                if (status.prime_hit) state_next = mcam_pkg::ST_AUG_INIT;
                else if (status.sweep_end && !status.again) state_next = mcam_pkg::ST_ADJ_MIN;
            end
            mcam_pkg::ST_ADJ_MIN:
            begin
                cmd = mcam_pkg::CMD_ADJ_MIN;
                // nothing uncovered: report every row unassigned
                if (status.sweep_end)
                    state_next = status.h_found ? mcam_pkg::ST_ADJ_UPD : mcam_pkg::ST_EMIT;
            end
            mcam_pkg::ST_ADJ_UPD:
            begin
                cmd = mcam_pkg::CMD_ADJ_UPD;
                if (status.sweep_end) state_next = mcam_pkg::ST_PRIME;
            end
            mcam_pkg::ST_AUG_INIT:
            begin
                cmd = mcam_pkg::CMD_AUG_INIT;
                state_next = mcam_pkg::ST_AUG_STEP;
            end
            mcam_pkg::ST_AUG_STEP:
            begin
                cmd = mcam_pkg::CMD_AUG_STEP;
                if (status.aug_stop) state_next = mcam_pkg::ST_AUG_END;
            end
            mcam_pkg::ST_AUG_END:
            begin
                cmd = mcam_pkg::CMD_AUG_END;
                state_next = mcam_pkg::ST_COUNT;
            end
            mcam_pkg::ST_EMIT:
            begin
                cmd = mcam_pkg::CMD_EMIT;
                if (status.emit_fire && status.emit_last) state_next = mcam_pkg::ST_IDLE;
            end
            default: state_next = mcam_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/min_cost_assignment_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_cost_assignment_matcher
// Loads a cost matrix one element per transaction and solves the minimum-cost
// assignment with the Munkres method, then reports one result per row.
//
//   channel   handshake                  payload
//   item      item_valid / item_ready    item   (mcam_pkg::item_t)
//   result    result_valid / result_ready result (mcam_pkg::result_t)
//
// Loading takes one element per cycle. A solve walks the cost memory through
// its single read port in sweeps, and its length is set by the number of
// prime and adjust sweeps. Reset clears all marks, no memory clearing pass.
// A stalled result holds the emit step only.
// ----------------------------------------------------------------------------
module min_cost_assignment_matcher #(
    parameter int MAX_SIZE  = 16,
    parameter int COST_BITS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    output logic               item_ready,
    input  mcam_pkg::item_t    item,
    output logic               result_valid,
    input  wire                result_ready,
    output mcam_pkg::result_t  result
);

    mcam_pkg::cmd_t       cmd;
    mcam_pkg::dp_status_t status;

    mcam_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .cmd        (cmd),
        .item_ready (item_ready)
    );

    mcam_dp #(
        .MAX_SIZE  (MAX_SIZE),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_valid   (item_valid),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status)
    );

endmodule
`default_nettype wire
